[rtl/imubq_pkg.sv]
// Package with constants, types and coefficient tables for the IMU biquad gravity splitter.
package imubq_pkg;

   localparam int WindowLength = 128;
   localparam int HopLength    = 64;
   localparam int CntW         = $clog2(WindowLength + HopLength + 1);

   localparam logic signed [31:0] NoiseCoef [5] = '{
      32'sd569047977, 32'sd1138095954, 32'sd569047977,
      -32'sd886086522, -32'sd316363563
   };
   localparam logic signed [31:0] GravCoef [5] = '{
      32'sd371559, 32'sd743118, 32'sd371559,
      32'sd2090250568, -32'sd1017994980
   };

   // Gyro scaling: 2^20 = 131 * GyroWhole + GyroRem, so the rounded quotient is
   // m * GyroWhole + floor((m * GyroRem + GyroRound) / 131). That last quotient is
   // taken as a product with Recip131 = ceil(2^32 / 131) followed by a 32-bit shift.
   localparam logic [13:0] GyroWhole = 14'd8004;
   localparam logic [5:0]  GyroRem   = 6'd52;
   localparam logic [6:0]  GyroRound = 7'd65;
   localparam logic [31:0] Recip131  = 32'd32786010;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_MAC,
      ST_WRITE,
      ST_BODY,
      ST_DONE
   } state_type;

endpackage

[rtl/imubq_mac.sv]
// Shared signed 33 x 32 multiplier with a registered product and a 66-bit accumulator.
module imubq_mac
   import imubq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               clear,
   input  logic               mul_en,
   input  logic               acc_en,
   input  logic signed [32:0] op_a,
   input  logic signed [31:0] op_b,
   output logic signed [64:0] prod,
   output logic signed [65:0] acc
);

   logic signed [64:0] prod_ff, prod_in;
   logic signed [65:0] acc_ff, acc_in;

   always_comb begin
      prod_in = mul_en ? op_a * op_b : prod_ff;
      acc_in  = clear ? '0 : (acc_en ? acc_ff + 66'(prod_ff) : acc_ff);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign prod = prod_ff;
   assign acc  = acc_ff;

endmodule

[rtl/imu_biquad_gravity_split.sv]
// Top level of the IMU biquad gravity splitter: sequencer, filter history and result register.
// Sequence per sample: the three gyro scalings, then the nine filters, then the body difference,
// then the response is posted. The block takes no new sample before the last one is through:
// every multiply goes through one shared 33 x 32 multiplier, and req_tready stays low until
// the rsp beat has been taken.
// Synchronous active-high reset clears filter history, the window counter and the handshake.
module imu_biquad_gravity_split
   import imubq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw
   input  logic [95:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // body_x, body_y, body_z, grav_x, grav_y, grav_z, rate_x, rate_y, rate_z
   output logic [287:0] rsp_tdata,
   // window_ready: this sample completes an analysis window.
   output logic         rsp_tlast
);

   state_type state_ff, state_in;

   // Step counters: channel (0..8) and tap/phase (0..5).
   logic [3:0] ch_ff, ch_in;
   logic [2:0] tap_ff, tap_in;

   // Filter histories: 9 filters (6 noise, 3 gravity) x 4 words, each a fixed place.
   logic signed [31:0] hist_ff [9][4];
   logic signed [31:0] hist_in [9][4];
   // Per-channel values: scaled inputs (0..5), then filtered outputs (0..8).
   logic signed [31:0] xin_ff [6];
   logic signed [31:0] xin_in [6];
   logic signed [31:0] yout_ff [9];
   logic signed [31:0] yout_in [9];
   logic signed [31:0] body_ff [3];
   logic signed [31:0] body_in [3];
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic ready_ff, ready_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] req_hold_ff [6];
   logic signed [15:0] req_hold_in [6];

   logic               mac_clear, mul_en, acc_en;
   logic signed [32:0] op_a;
   logic signed [31:0] op_b;
   logic signed [64:0] prod;
   logic signed [65:0] acc;

   imubq_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .clear  (mac_clear),
      .mul_en (mul_en),
      .acc_en (acc_en),
      .op_a   (op_a),
      .op_b   (op_b),
      .prod   (prod),
      .acc    (acc)
   );

   logic signed [31:0] x_cur;
   logic signed [31:0] coef_cur;
   logic               is_grav;
   logic [3:0]         hidx;
   logic signed [65:0] rnd;
   logic signed [35:0] yq;
   logic signed [31:0] ysat;
   logic [16:0]        gmag;
   logic [20:0]        tfrac;
   logic [27:0]        q;
   logic signed [15:0] graw;
   logic               gneg;
   logic signed [32:0] bdiff;

   // Rounds the accumulator to Q12.20 and saturates.
   always_comb begin
      rnd  = acc + 66'sd536870912;
      yq   = 36'(rnd >>> 30);
      if (yq > 36'sd2147483647) begin
         ysat = 32'sh7fffffff;
      end else if (yq < -36'sd2147483648) begin
         ysat = 32'sh80000000;
      end else begin
         ysat = yq[31:0];
      end
   end

   // Gyro scaling on the magnitude m: the product holds (m * GyroRem + GyroRound) * Recip131,
   // whose bits above 32 are the small quotient; m * GyroWhole is added to it.
   always_comb begin
      graw = '0;
      if (ch_ff < 4'd6 && ch_ff >= 4'd3) begin
         graw = req_hold_ff[ch_ff[2:0]];
      end
      gneg  = graw[15];
      gmag  = 17'(gneg ? -32'(graw) : 32'(graw));
      tfrac = 21'(gmag) * 21'(GyroRem) + 21'(GyroRound);
      q     = 28'(gmag) * 28'(GyroWhole) + 28'(prod[45:32]);
   end

   always_comb begin
      is_grav  = (ch_ff >= 4'd6);
      hidx     = ch_ff;
      x_cur    = is_grav ? yout_ff[ch_ff - 4'd6] : xin_ff[ch_ff[2:0]];
      coef_cur = is_grav ? GravCoef[tap_ff] : NoiseCoef[tap_ff];
   end

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      tap_in       = tap_ff;
      hist_in      = hist_ff;
      xin_in       = xin_ff;
      yout_in      = yout_ff;
      body_in      = body_ff;
      cnt_in       = cnt_ff;
      ready_in     = ready_ff;
      rsp_valid_in = rsp_valid_ff;
      req_hold_in  = req_hold_ff;
      mac_clear    = 1'b0;
      mul_en       = 1'b0;
      acc_en       = 1'b0;
      op_a         = '0;
      op_b         = '0;
      bdiff        = '0;
      req_tready   = (state_ff == ST_IDLE) && !rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               for (int i = 0; i < 6; i++) begin
                  req_hold_in[i] = req_tdata[16*i +: 16];
               end
               for (int i = 0; i < 3; i++) begin
                  xin_in[i] = {{10{req_tdata[16*i+15]}}, req_tdata[16*i +: 16], 6'd0};
               end
               ch_in    = 4'd3;
               tap_in   = '0;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            // tap 0: multiply, tap 1: product ready.
            if (tap_ff == 3'd0) begin
               mul_en = 1'b1;
               op_a   = 33'(tfrac);
               op_b   = $signed(Recip131);
               tap_in = 3'd1;
            end else begin
               xin_in[ch_ff[2:0]] = gneg ? -$signed({4'd0, q}) : $signed({4'd0, q});
               tap_in = '0;
               if (ch_ff == 4'd5) begin
                  ch_in     = '0;
                  mac_clear = 1'b1;
                  state_in  = ST_MAC;
               end else begin
                  ch_in = ch_ff + 4'd1;
               end
            end
         end
         ST_MAC: begin
            // tap 0..4 issue products; tap 1..5 accumulate the previous one.
            if (tap_ff <= 3'd4) begin
               mul_en = 1'b1;
               op_a   = 33'(coef_cur);
               op_b   = (tap_ff == 3'd0) ? x_cur : hist_ff[hidx][2'(tap_ff - 3'd1)];
            end
            if (tap_ff != 3'd0) begin
               acc_en = 1'b1;
            end
            if (tap_ff == 3'd5) begin
               state_in = ST_WRITE;
               tap_in   = '0;
            end else begin
               tap_in = tap_ff + 3'd1;
            end
         end
         ST_WRITE: begin
            yout_in[ch_ff]    = ysat;
            hist_in[hidx][1]  = hist_ff[hidx][0];
            hist_in[hidx][0]  = x_cur;
            hist_in[hidx][3]  = hist_ff[hidx][2];
            hist_in[hidx][2]  = ysat;
            mac_clear         = 1'b1;
            if (ch_ff == 4'd8) begin
               ch_in    = '0;
               state_in = ST_BODY;
            end else begin
               ch_in    = ch_ff + 4'd1;
               state_in = ST_MAC;
            end
         end
         ST_BODY: begin
            for (int i = 0; i < 3; i++) begin
               bdiff = 33'(yout_ff[i]) - 33'(yout_ff[i+6]);
               if (bdiff > 33'sd2147483647) begin
                  body_in[i] = 32'sh7fffffff;
               end else if (bdiff < -33'sd2147483648) begin
                  body_in[i] = 32'sh80000000;
               end else begin
                  body_in[i] = bdiff[31:0];
               end
            end
            if (cnt_ff + CntW'(1) == CntW'(WindowLength)) begin
               ready_in = 1'b1;
               cnt_in   = cnt_ff + CntW'(1);
            end else if (cnt_ff + CntW'(1) >= CntW'(WindowLength + HopLength)) begin
               ready_in = 1'b1;
               cnt_in   = CntW'(WindowLength);
            end else begin
               ready_in = 1'b0;
               cnt_in   = cnt_ff + CntW'(1);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= '0;
         tap_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int f = 0; f < 9; f++) begin
            for (int w = 0; w < 4; w++) begin
               hist_ff[f][w] <= '0;
            end
         end
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         tap_ff       <= tap_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         hist_ff      <= hist_in;
      end
      xin_ff      <= xin_in;
      yout_ff     <= yout_in;
      body_ff     <= body_in;
      ready_ff    <= ready_in;
      req_hold_ff <= req_hold_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {yout_ff[5], yout_ff[4], yout_ff[3],
                        yout_ff[8], yout_ff[7], yout_ff[6],
                        body_ff[2], body_ff[1], body_ff[0]};
   assign rsp_tlast  = ready_ff;

endmodule
